// ===== hdl/bfur_pkg.sv =====
// Types, register codes and arithmetic helpers for the roll basis pipeline.
// No dependencies; imported by basis_from_forward_up_roll.
`default_nettype none

package bfur_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_DEGEN_THR = 2'd0;
	localparam logic [1:0] REG_AXIS_LIM  = 2'd1;

	localparam logic [14:0] DEGEN_THR_RST = 15'd2;
	localparam logic [14:0] AXIS_LIM_RST  = 15'd16220;

	localparam logic [15:0] ONE_Q14 = 16'd16384;

	// quarter-wave sine polynomial coefficients
	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [13:0] SIN_B = 14'd10512;
	localparam logic [10:0] SIN_C = 11'd1160;

	// fields that ride along the whole pipe
	typedef struct packed {
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fz;
		logic [15:0] ang;
	} carry_t;

	// one square root iteration: remainder and partial root
	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} rt_t;

	// square root stage payload, main and fallback paths side by side
	typedef struct packed {
		rt_t             m;
		rt_t             f;
		logic [2:0][32:0] c;
		logic [2:0][32:0] g;
		carry_t          cy;
	} isq_t;

	// divider stage payload
	typedef struct packed {
		logic [2:0][45:0] rem;
		logic [2:0][14:0] q;
		logic [2:0]       neg;
		logic [31:0]      d;
		logic             zero;
		logic             fb;
		carry_t           cy;
	} dv_t;

	function automatic rt_t isq_step(input rt_t a, input logic [63:0] bitv);
		rt_t         o;
		logic [63:0] t;
		t = a.r + bitv;
		if (a.v >= t) begin
			o.v = a.v - t;
			o.r = (a.r >> 1) + bitv;
		end else begin
			o.v = a.v;
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	// shift right by 14, halves away from zero
	function automatic logic signed [39:0] rnd14(input logic signed [39:0] v);
		logic signed [39:0] m;
		if (v >= 0) begin
			m = (v + 40'sd8192) >>> 14;
			return m;
		end
		m = (-v + 40'sd8192) >>> 14;
		return -m;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767)
			return 16'sh7fff;
		if (v < -40'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/basis_from_forward_up_roll.sv =====
// Roll basis pipeline: right = normalise(up x fwd), up = fwd x right, both rolled.
// Depends on bfur_pkg.
//
//  channel   | signals                                      | handshake
//  ----------+----------------------------------------------+-------------------------
//  item in   | fwd_*, hint_up_*, roll_angle                 | start & !busy
//  result    | rolled_right_*, axis_fwd_*, rolled_up_*,     | done strobe, one cycle
//            | fallback_used                                |
//  config    | cfg_index, cfg_data                          | cfg_valid & cfg_ready
//
// One item per cycle through 57 register stages; the depth is set by the two
// 32-step square root chains (one root bit per stage) and the 15-step restoring
// divider.
// busy is never raised and the result side cannot stall, so the pipe always moves.
// arst_n clears the valid bits and loads register reset values; data is unreset.
`default_nettype none

module basis_from_forward_up_roll
	import bfur_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire signed [15:0] fwd_x,
	input  wire signed [15:0] fwd_y,
	input  wire signed [15:0] fwd_z,
	input  wire signed [15:0] hint_up_x,
	input  wire signed [15:0] hint_up_y,
	input  wire signed [15:0] hint_up_z,
	input  wire        [15:0] roll_angle,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire        [1:0]  cfg_index,
	input  wire        [15:0] cfg_data,
	output logic              done,
	output logic signed [15:0] rolled_right_x,
	output logic signed [15:0] rolled_right_y,
	output logic signed [15:0] rolled_right_z,
	output logic signed [15:0] axis_fwd_x,
	output logic signed [15:0] axis_fwd_y,
	output logic signed [15:0] axis_fwd_z,
	output logic signed [15:0] rolled_up_x,
	output logic signed [15:0] rolled_up_y,
	output logic signed [15:0] rolled_up_z,
	output logic              fallback_used
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [14:0] degen_thr_q;
	logic [14:0] axis_lim_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degen_thr_q <= DEGEN_THR_RST;
			axis_lim_q  <= AXIS_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEGEN_THR: degen_thr_q <= cfg_data[14:0];
				REG_AXIS_LIM:  axis_lim_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	wire in_acc = start && !busy;

	// ------------------------------------------------------------------
	// stage 1: cross products, hint x fwd and fallback axis x fwd
	// ------------------------------------------------------------------
	logic             v_s1;
	carry_t           cy_s1;
	logic [2:0][32:0] c_s1;
	logic [2:0][32:0] g_s1;

	logic signed [32:0] cx, cyy, cz;
	logic signed [32:0] fxk, fyk, fzk;
	logic [15:0]        afz;

	always_comb begin
		cx  = 33'(hint_up_y) * 33'(fwd_z) - 33'(hint_up_z) * 33'(fwd_y);
		cyy = 33'(hint_up_z) * 33'(fwd_x) - 33'(hint_up_x) * 33'(fwd_z);
		cz  = 33'(hint_up_x) * 33'(fwd_y) - 33'(hint_up_y) * 33'(fwd_x);
		fxk = 33'(fwd_x) <<< 14;
		fyk = 33'(fwd_y) <<< 14;
		fzk = 33'(fwd_z) <<< 14;
		afz = fwd_z[15] ? 16'(-fwd_z) : 16'(fwd_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		cy_s1 <= '{fx: fwd_x, fy: fwd_y, fz: fwd_z, ang: roll_angle};
		c_s1  <= {cz, cyy, cx};
		if (afz < {1'b0, axis_lim_q})
			g_s1 <= {33'sd0, fxk, -fyk};  // world Z
		else
			g_s1 <= {fyk, -fzk, 33'sd0};  // world X
	end

	// ------------------------------------------------------------------
	// stage 2: squares
	// ------------------------------------------------------------------
	logic             v_s2;
	carry_t           cy_s2;
	logic [2:0][32:0] c_s2, g_s2;
	logic [2:0][63:0] sq_s2, gq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		logic [32:0] mc, mg;
		cy_s2 <= cy_s1;
		c_s2  <= c_s1;
		g_s2  <= g_s1;
		for (int i = 0; i < 3; i++) begin
			mc = c_s1[i][32] ? -c_s1[i] : c_s1[i];
			mg = g_s1[i][32] ? -g_s1[i] : g_s1[i];
			sq_s2[i] <= 64'(mc[31:0]) * 64'(mc[31:0]);
			gq_s2[i] <= 64'(mg[31:0]) * 64'(mg[31:0]);
		end
	end

	// ------------------------------------------------------------------
	// stage 3: sums of squares, then 32 root stages (4..35)
	// ------------------------------------------------------------------
	isq_t isq_s   [0:32];
	logic isq_v_s [0:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			isq_v_s[0] <= 1'b0;
		else
			isq_v_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		isq_s[0].m.v <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		isq_s[0].m.r <= '0;
		isq_s[0].f.v <= gq_s2[0] + gq_s2[1] + gq_s2[2];
		isq_s[0].f.r <= '0;
		isq_s[0].c   <= c_s2;
		isq_s[0].g   <= g_s2;
		isq_s[0].cy  <= cy_s2;
	end

	for (genvar k = 0; k < 32; k++) begin : g_isq
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
		isq_t nxt;

		always_comb begin
			nxt   = isq_s[k];
			nxt.m = isq_step(isq_s[k].m, BITV);
			nxt.f = isq_step(isq_s[k].f, BITV);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				isq_v_s[k + 1] <= 1'b0;
			else
				isq_v_s[k + 1] <= isq_v_s[k];
		end

		always_ff @(posedge clk) begin
			isq_s[k + 1] <= nxt;
		end
	end

	// ------------------------------------------------------------------
	// stage 36: degenerate test, pick path, set up the dividers
	// ------------------------------------------------------------------
	dv_t  dv_s   [0:15];
	logic dv_v_s [0:15];

	dv_t  dv_init;

	always_comb begin
		logic [31:0]      len;
		logic [2:0][32:0] cs;
		logic [32:0]      mag;
		dv_init.fb = isq_s[32].m.r < {35'd0, degen_thr_q, 14'd0};
		len        = dv_init.fb ? isq_s[32].f.r[31:0] : isq_s[32].m.r[31:0];
		cs         = dv_init.fb ? isq_s[32].g : isq_s[32].c;
		dv_init.d    = len;
		dv_init.zero = (len == '0);
		dv_init.cy   = isq_s[32].cy;
		for (int i = 0; i < 3; i++) begin
			mag               = cs[i][32] ? -cs[i] : cs[i];
			dv_init.neg[i]    = cs[i][32];
			dv_init.q[i]      = '0;
			dv_init.rem[i]    = {mag[31:0], 14'd0} + 46'(len >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else
			dv_v_s[0] <= isq_v_s[32];
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= dv_init;
	end

	// stages 37..51: one quotient bit per stage, all three components
	for (genvar j = 0; j < 15; j++) begin : g_div
		localparam int SH = 14 - j;
		dv_t        nxt;
		logic [46:0] dsh;

		always_comb begin
			nxt = dv_s[j];
			dsh = {15'd0, dv_s[j].d} << SH;
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, dv_s[j].rem[i]} >= dsh) begin
					nxt.rem[i]   = dv_s[j].rem[i] - dsh[45:0];
					nxt.q[i][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j + 1] <= 1'b0;
			else
				dv_v_s[j + 1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			dv_s[j + 1] <= nxt;
		end
	end

	// ------------------------------------------------------------------
	// stage 52: signed right axis; sine/cosine chain starts (52..55)
	// ------------------------------------------------------------------
	logic                    v_s52, v_s53, v_s54, v_s55, v_s56, v_s57;
	carry_t                  cy_s52, cy_s53, cy_s54, cy_s55, cy_s56;
	logic                    fb_s52, fb_s53, fb_s54, fb_s55, fb_s56;
	logic signed [15:0]      rt_s52 [3], rt_s53 [3], rt_s54 [3], rt_s55 [3];

	// index 0 is sine, index 1 is cosine
	logic [14:0] tx_s52  [2];
	logic [14:0] tx2_s52 [2];
	logic        tn_s52  [2];
	logic [14:0] tx_s53  [2];
	logic [14:0] tx2_s53 [2];
	logic [13:0] tt_s53  [2];
	logic        tn_s53  [2];
	logic [14:0] tx_s54  [2];
	logic [14:0] tt2_s54 [2];
	logic        tn_s54  [2];
	logic signed [15:0] sc_s55 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s52 <= 1'b0;
			v_s53 <= 1'b0;
			v_s54 <= 1'b0;
			v_s55 <= 1'b0;
			v_s56 <= 1'b0;
			v_s57 <= 1'b0;
		end else begin
			v_s52 <= dv_v_s[15];
			v_s53 <= v_s52;
			v_s54 <= v_s53;
			v_s55 <= v_s54;
			v_s56 <= v_s55;
			v_s57 <= v_s56;
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] a;
		logic [14:0] x;
		logic [29:0] xx;
		cy_s52 <= dv_s[15].cy;
		fb_s52 <= dv_s[15].fb;
		for (int i = 0; i < 3; i++) begin
			if (dv_s[15].zero)
				rt_s52[i] <= (i == 0) ? ONE_Q14 : 16'd0;
			else if (dv_s[15].neg[i])
				rt_s52[i] <= -{1'b0, dv_s[15].q[i]};
			else
				rt_s52[i] <= {1'b0, dv_s[15].q[i]};
		end
		for (int n = 0; n < 2; n++) begin
			a  = (n == 0) ? dv_s[15].cy.ang : dv_s[15].cy.ang + ONE_Q14;
			x  = a[14] ? 15'(ONE_Q14) - {1'b0, a[13:0]} : {1'b0, a[13:0]};
			xx = 30'(x) * 30'(x);
			tx_s52[n]  <= x;
			tx2_s52[n] <= xx[28:14];
			tn_s52[n]  <= a[15];
		end
	end

	// ------------------------------------------------------------------
	// stage 53: up = fwd x right at Q.28; sine inner term
	// ------------------------------------------------------------------
	logic signed [32:0] upm_s53 [3];

	always_ff @(posedge clk) begin
		logic signed [15:0] f0, f1, f2;
		logic [25:0]        xc;
		f0 = $signed(cy_s52.fx);
		f1 = $signed(cy_s52.fy);
		f2 = $signed(cy_s52.fz);
		cy_s53 <= cy_s52;
		fb_s53 <= fb_s52;
		rt_s53 <= rt_s52;
		upm_s53[0] <= 33'(f1) * 33'(rt_s52[2]) - 33'(f2) * 33'(rt_s52[1]);
		upm_s53[1] <= 33'(f2) * 33'(rt_s52[0]) - 33'(f0) * 33'(rt_s52[2]);
		upm_s53[2] <= 33'(f0) * 33'(rt_s52[1]) - 33'(f1) * 33'(rt_s52[0]);
		for (int n = 0; n < 2; n++) begin
			xc = 26'(tx2_s52[n]) * 26'(SIN_C);
			tx_s53[n]  <= tx_s52[n];
			tx2_s53[n] <= tx2_s52[n];
			tt_s53[n]  <= SIN_B - {3'd0, xc[24:14]};
			tn_s53[n]  <= tn_s52[n];
		end
	end

	// ------------------------------------------------------------------
	// stage 54: round up axis; sine middle term
	// ------------------------------------------------------------------
	logic signed [17:0] up_s54 [3], up_s55 [3];

	always_ff @(posedge clk) begin
		logic signed [39:0] r;
		logic [28:0]        xt;
		cy_s54 <= cy_s53;
		fb_s54 <= fb_s53;
		rt_s54 <= rt_s53;
		for (int i = 0; i < 3; i++) begin
			r = rnd14(40'(upm_s53[i]));
			up_s54[i] <= r[17:0];
		end
		for (int n = 0; n < 2; n++) begin
			xt = 29'(tx2_s53[n]) * 29'(tt_s53[n]);
			tx_s54[n]  <= tx_s53[n];
			tt2_s54[n] <= SIN_A - {1'b0, xt[27:14]};
			tn_s54[n]  <= tn_s53[n];
		end
	end

	// ------------------------------------------------------------------
	// stage 55: sine and cosine done
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		logic [29:0] p;
		cy_s55 <= cy_s54;
		fb_s55 <= fb_s54;
		rt_s55 <= rt_s54;
		up_s55 <= up_s54;
		for (int n = 0; n < 2; n++) begin
			p = 30'(tx_s54[n]) * 30'(tt2_s54[n]);
			sc_s55[n] <= tn_s54[n] ? -{1'b0, p[28:14]} : {1'b0, p[28:14]};
		end
	end

	// ------------------------------------------------------------------
	// stage 56: roll products
	// ------------------------------------------------------------------
	logic signed [31:0] prc_s56 [3], prs_s56 [3];
	logic signed [33:0] puc_s56 [3], pus_s56 [3];

	always_ff @(posedge clk) begin
		cy_s56 <= cy_s55;
		fb_s56 <= fb_s55;
		for (int i = 0; i < 3; i++) begin
			prc_s56[i] <= rt_s55[i] * sc_s55[1];
			prs_s56[i] <= rt_s55[i] * sc_s55[0];
			puc_s56[i] <= 34'(up_s55[i]) * 34'(sc_s55[1]);
			pus_s56[i] <= 34'(up_s55[i]) * 34'(sc_s55[0]);
		end
	end

	// ------------------------------------------------------------------
	// stage 57: round, saturate, present
	// ------------------------------------------------------------------
	logic signed [2:0][15:0] rr_s57, ru_s57;
	carry_t                  cy_s57;
	logic                    fb_s57;

	always_ff @(posedge clk) begin
		cy_s57 <= cy_s56;
		fb_s57 <= fb_s56;
		for (int i = 0; i < 3; i++) begin
			rr_s57[i] <= sat16(rnd14(40'(prc_s56[i]) + 40'(pus_s56[i])));
			ru_s57[i] <= sat16(rnd14(40'(puc_s56[i]) - 40'(prs_s56[i])));
		end
	end

	assign done           = v_s57;
	assign rolled_right_x = rr_s57[0];
	assign rolled_right_y = rr_s57[1];
	assign rolled_right_z = rr_s57[2];
	assign axis_fwd_x     = $signed(cy_s57.fx);
	assign axis_fwd_y     = $signed(cy_s57.fy);
	assign axis_fwd_z     = $signed(cy_s57.fz);
	assign rolled_up_x    = ru_s57[0];
	assign rolled_up_y    = ru_s57[1];
	assign rolled_up_z    = ru_s57[2];
	assign fallback_used  = fb_s57;

endmodule

`default_nettype wire

// ===== test/tb_basis_from_forward_up_roll.sv =====
// Testbench for the roll basis pipeline: directed corners, register sweeps and random items.
// Depends on bfur_pkg and basis_from_forward_up_roll; predicts every result in-bench.
`timescale 1ns / 100ps
`default_nettype none

module tb_basis_from_forward_up_roll
	import bfur_pkg::*;
;

	// expected content of one result item
	typedef struct {
		logic signed [15:0] rr [3];
		logic signed [15:0] fw [3];
		logic signed [15:0] ru [3];
		logic               fb;
	} basis_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 64;   // a little over the pipe depth

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] fwd_x, fwd_y, fwd_z;
	logic signed [15:0] hint_up_x, hint_up_y, hint_up_z;
	logic [15:0] roll_angle;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic done;
	logic signed [15:0] rolled_right_x, rolled_right_y, rolled_right_z;
	logic signed [15:0] axis_fwd_x, axis_fwd_y, axis_fwd_z;
	logic signed [15:0] rolled_up_x, rolled_up_y, rolled_up_z;
	logic fallback_used;

	// predictor copy of the two registers
	logic [14:0] thr_model;
	logic [14:0] lim_model;

	basis_t pending_bases [$];
	int mismatches;
	int cycles;
	int idle_pct;

	basis_from_forward_up_roll DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
		.hint_up_x(hint_up_x), .hint_up_y(hint_up_y), .hint_up_z(hint_up_z),
		.roll_angle(roll_angle),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done),
		.rolled_right_x(rolled_right_x), .rolled_right_y(rolled_right_y),
		.rolled_right_z(rolled_right_z),
		.axis_fwd_x(axis_fwd_x), .axis_fwd_y(axis_fwd_y), .axis_fwd_z(axis_fwd_z),
		.rolled_up_x(rolled_up_x), .rolled_up_y(rolled_up_y), .rolled_up_z(rolled_up_z),
		.fallback_used(fallback_used)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// halves away from zero
	function automatic longint round14(longint v);
		if (v >= 0)
			return (v + 8192) >>> 14;
		return -((-v + 8192) >>> 14);
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint sine_q14(logic [15:0] a);
		int unsigned q, r, x, x2, t, t2, s;
		q = a[15:14];
		r = a[13:0];
		x = q[0] ? 16384 - r : r;
		x2 = (x * x) >> 14;
		t = 10512 - ((x2 * 1160) >> 14);
		t2 = 25736 - ((x2 * t) >> 14);
		s = (x * t2) >> 14;
		return q[1] ? -longint'(s) : longint'(s);
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint c [3]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint unsigned length_of(longint c [3]);
		longint unsigned s;
		longint unsigned m;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m = (c[i] < 0) ? -c[i] : c[i];
			s += m * m;
		end
		return int_sqrt(s);
	endfunction

	function automatic basis_t calc_basis(logic signed [15:0] f [3], logic signed [15:0] h [3],
			logic [15:0] ang);
		basis_t o;
		longint fv [3], hv [3], c [3], rt [3], up [3], ax [3];
		longint unsigned len;
		longint l, m, cs, sn, fz_abs;
		o.fb = 1'b0;
		for (int i = 0; i < 3; i++) begin
			fv[i] = f[i];
			hv[i] = h[i];
			ax[i] = 0;
		end
		cross3(hv, fv, c);
		len = length_of(c);
		if (len < (longint'(thr_model) << 14)) begin
			o.fb = 1'b1;
			fz_abs = (fv[2] < 0) ? -fv[2] : fv[2];
			if (fz_abs < longint'(lim_model))
				ax[2] = 16384;
			else
				ax[0] = 16384;
			cross3(ax, fv, c);
			len = length_of(c);
		end
		if (len == 0) begin
			// zero cross: forward is zero or parallel to the axis it was crossed with
			rt[0] = 16384;
			rt[1] = 0;
			rt[2] = 0;
		end else begin
			l = len;
			for (int i = 0; i < 3; i++) begin
				m = (((c[i] < 0) ? -c[i] : c[i]) * 16384 + l / 2) / l;
				rt[i] = (c[i] < 0) ? -m : m;
			end
		end
		cross3(fv, rt, up);
		for (int i = 0; i < 3; i++)
			up[i] = round14(up[i]);
		sn = sine_q14(ang);
		cs = sine_q14(ang + 16'd16384);
		for (int i = 0; i < 3; i++) begin
			o.rr[i] = 16'(clamp16(round14(rt[i] * cs + up[i] * sn)));
			o.ru[i] = 16'(clamp16(round14(up[i] * cs - rt[i] * sn)));
			o.fw[i] = f[i];
		end
		return o;
	endfunction

	// ---------------------------------------------------------------- monitors

	// register and item acceptance, sampled on the edge that takes them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_model <= DEGEN_THR_RST;
			lim_model <= AXIS_LIM_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DEGEN_THR)
					thr_model <= cfg_data[14:0];
				else if (cfg_index == REG_AXIS_LIM)
					lim_model <= cfg_data[14:0];
			end
			if (start && busy === 1'b0)
				pending_bases.push_back(calc_basis('{fwd_x, fwd_y, fwd_z},
					'{hint_up_x, hint_up_y, hint_up_z}, roll_angle));
		end
	end

	// result checker: done strobe compared against the oldest prediction
	always @(posedge clk) begin
		basis_t e;
		logic signed [15:0] got_rr [3], got_fw [3], got_ru [3];
		logic bad;
		if (arst_n && done === 1'b1) begin
			got_rr = '{rolled_right_x, rolled_right_y, rolled_right_z};
			got_fw = '{axis_fwd_x, axis_fwd_y, axis_fwd_z};
			got_ru = '{rolled_up_x, rolled_up_y, rolled_up_z};
			if (pending_bases.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item at cycle %0d", cycles);
			end else begin
				e = pending_bases.pop_front();
				bad = (fallback_used !== e.fb);
				for (int i = 0; i < 3; i++)
					bad |= (got_rr[i] !== e.rr[i]) || (got_fw[i] !== e.fw[i])
						|| (got_ru[i] !== e.ru[i]);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at cycle %0d", cycles);
						$display("  exp rr %0d %0d %0d fw %0d %0d %0d ru %0d %0d %0d fb %0b",
							e.rr[0], e.rr[1], e.rr[2], e.fw[0], e.fw[1], e.fw[2],
							e.ru[0], e.ru[1], e.ru[2], e.fb);
						$display("  got rr %0d %0d %0d fw %0d %0d %0d ru %0d %0d %0d fb %0b",
							got_rr[0], got_rr[1], got_rr[2], got_fw[0], got_fw[1],
							got_fw[2], got_ru[0], got_ru[1], got_ru[2], fallback_used);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- drivers

	// one item; start stays high across back-to-back items
	task automatic send_item(logic signed [15:0] fx, fy, fz, hx, hy, hz, logic [15:0] ang);
		start <= 1'b1;
		fwd_x <= fx;
		fwd_y <= fy;
		fwd_z <= fz;
		hint_up_x <= hx;
		hint_up_y <= hy;
		hint_up_z <= hz;
		roll_angle <= ang;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	// hold off until the pipe is empty
	task automatic drain_pipe();
		start <= 1'b0;
		while (pending_bases.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom_range(31) - 16);
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_corners();
		// zero forward: fallback leaves a zero cross, right defaults to +X
		send_item(0, 0, 0, 0, 16384, 0, 0);
		// forward on Z with parallel hint: |z| past the reset limit, world X stands in
		send_item(0, 0, 16384, 0, 0, 16384, 16384);
		// forward on X with parallel hint: world Z stands in
		send_item(16384, 0, 0, -16384, 0, 0, 32768);
		// forward parallel to world Z below the limit is impossible; z just below and at the reset limit
		send_item(0, 5000, 16219, 0, 5000, 16219, 49152);
		send_item(0, 5000, 16220, 0, 5000, 16220, 65535);
		// ordinary basis, every quadrant of the roll
		send_item(0, 16384, 0, 0, 0, 16384, 0);
		send_item(0, 16384, 0, 0, 0, 16384, 8192);
		send_item(0, 16384, 0, 0, 0, 16384, 24576);
		send_item(0, 16384, 0, 0, 0, 16384, 40960);
		send_item(0, 16384, 0, 0, 0, 16384, 57344);
		// field extremes, saturation of non-unit forward
		send_item(-32768, -32768, -32768, 32767, -32768, 32767, 12345);
		send_item(32767, 32767, 32767, -32768, 32767, -32768, 65535);
		send_item(32767, -32768, 0, 0, 0, 32767, 8192);
		send_item(-32768, 0, 32767, 32767, 32767, 32767, 1);
		// short cross that is still nonzero after fallback
		send_item(1, 0, 16384, 0, 0, 1, 0);
		send_item(0, 1, 0, 0, 2, 0, 16384);
		drain_pipe();
	endtask

	task automatic test_random(int n);
		logic signed [15:0] f [3], h [3];
		int k;
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < 3; i++)
				f[i] = rand_comp();
			case ($urandom_range(3))
				// hint parallel to forward: degenerate path
				0: begin
					k = $urandom_range(2);
					for (int i = 0; i < 3; i++)
						h[i] = (k == 0) ? f[i] : (k == 1) ? -f[i] : f[i] >>> 1;
				end
				// hint nearly parallel
				1: for (int i = 0; i < 3; i++)
					h[i] = 16'(f[i] + $urandom_range(6) - 3);
				default: for (int i = 0; i < 3; i++)
					h[i] = rand_comp();
			endcase
			send_item(f[0], f[1], f[2], h[0], h[1], h[2], 16'($urandom));
		end
		drain_pipe();
	endtask

	task automatic test_register_sweep(logic [15:0] thr, logic [15:0] lim, int n);
		write_reg(REG_DEGEN_THR, thr);
		write_reg(REG_AXIS_LIM, lim);
		// indexes past the list are ignored
		write_reg(2'd2, 16'($urandom));
		write_reg(2'd3, 16'($urandom));
		test_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fwd_x = '0;
		fwd_y = '0;
		fwd_z = '0;
		hint_up_x = '0;
		hint_up_y = '0;
		hint_up_z = '0;
		roll_angle = '0;
		mismatches = 0;
		cycles = 0;
		idle_pct = 11;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values first
		test_corners();
		test_random(250);

		test_register_sweep(16'd0, 16'd16384, 150);
		idle_pct = 70;
		test_register_sweep(16'hffff, 16'd0, 150);
		test_register_sweep(16'h8003, 16'h7fff, 150);
		test_corners();
		idle_pct = 0;
		test_register_sweep(16'd100, 16'd8000, 200);
		test_register_sweep(16'd2, 16'd16220, 250);

		while (pending_bases.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
